FILE: rtl/tief_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tief_pkg
// Shared types and constants of the terminal input escape filter.
// ----------------------------------------------------------------------------
package tief_pkg;

  localparam logic [7:0] ESC_BYTE = 8'h1b;

  // what the back end emits around the held bytes of one job
  typedef struct packed {
    logic       esc;
    logic       tail_valid;
    logic [7:0] tail_byte;
  } job_ctl_t;

endpackage

FILE: rtl/tief_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tief_front
// Accepts input bytes, tracks the escape parser and the held bytes, and
// turns each byte into at most one emission job for the back end.
// ----------------------------------------------------------------------------
module tief_front #(
  parameter int HELD_N = 14,
  parameter int CW     = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       message_end_i,
  output logic                       full_o,
  input  logic                       q_full_i,
  output logic                       job_push_o,
  output tief_pkg::job_ctl_t         job_ctl_o,
  output logic [CW-1:0]              job_cnt_o,
  output logic [HELD_N-1:0][7:0]     job_held_o
);
  import tief_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_CSI,
    MODE_SS3
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [HELD_N-1:0][7:0] held_q, held_d;

  logic          accept;
  logic          do_hold;
  logic          fail;
  logic          idle_path;
  logic [CW-1:0] emit_cnt;
  job_ctl_t      ctl;

  function automatic logic control_passes(logic [7:0] b);
    return b == 8'h09 || b == 8'h0a || b == 8'h0d || b == 8'h08 ||
           b == 8'h7f || b == 8'h03 || b == 8'h04 || b == 8'h1a;
  endfunction

  function automatic logic csi_param(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || b == 8'h3b || b == 8'h3f || b == 8'h3a;
  endfunction

  function automatic logic csi_final(logic [7:0] b);
    return b == "A" || b == "B" || b == "C" || b == "D" || b == "F" ||
           b == "H" || b == "~";
  endfunction

  function automatic logic ss3_final(logic [7:0] b);
    return b == "A" || b == "B" || b == "C" || b == "D" || b == "F" ||
           b == "H" || b == "P" || b == "Q" || b == "R" || b == "S";
  endfunction

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;

  always_comb begin
    mode_d         = mode_q;
    cnt_d          = cnt_q;
    do_hold        = 1'b0;
    fail           = 1'b0;
    idle_path      = 1'b0;
    emit_cnt       = '0;
    ctl.esc        = 1'b0;
    ctl.tail_valid = 1'b0;
    ctl.tail_byte  = data_byte_i;

    case (mode_q)
      MODE_IDLE: begin
        idle_path = 1'b1;
      end
      MODE_ESC: begin
        if (data_byte_i == "[") begin
          do_hold = 1'b1;
          cnt_d   = CW'(1);
          mode_d  = MODE_CSI;
        end else if (data_byte_i == "O") begin
          do_hold = 1'b1;
          cnt_d   = CW'(1);
          mode_d  = MODE_SS3;
        end else begin
          fail = 1'b1;
        end
      end
      MODE_CSI: begin
        if (csi_param(data_byte_i)) begin
          if (cnt_q < CW'(HELD_N)) begin
            do_hold = 1'b1;
            cnt_d   = cnt_q + CW'(1);
          end else begin
            fail = 1'b1;
          end
        end else if (csi_final(data_byte_i)) begin
          ctl.esc        = 1'b1;
          ctl.tail_valid = 1'b1;
          emit_cnt       = cnt_q;
          mode_d         = MODE_IDLE;
          cnt_d          = '0;
        end else begin
          fail = 1'b1;
        end
      end
      MODE_SS3: begin
        if (ss3_final(data_byte_i)) begin
          ctl.esc        = 1'b1;
          ctl.tail_valid = 1'b1;
          emit_cnt       = cnt_q;
          mode_d         = MODE_IDLE;
          cnt_d          = '0;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        idle_path = 1'b1;
      end
    endcase

    if (fail) begin
      emit_cnt  = cnt_q;
      mode_d    = MODE_IDLE;
      cnt_d     = '0;
      idle_path = 1'b1;
    end

    if (idle_path) begin
      if (data_byte_i == ESC_BYTE) begin
        mode_d = MODE_ESC;
        cnt_d  = '0;
      end else if (data_byte_i >= 8'h20 || control_passes(data_byte_i)) begin
        ctl.tail_valid = 1'b1;
      end
    end

    // message end flushes whatever is still held, without the escape
    if (message_end_i && mode_d != MODE_IDLE) begin
      if (emit_cnt == '0) begin
        emit_cnt = cnt_d;
      end
      mode_d = MODE_IDLE;
      cnt_d  = '0;
    end
  end

  always_comb begin
    held_d = held_q;
    for (int i = 0; i < HELD_N; i++) begin
      if (do_hold && cnt_q == CW'(i)) begin
        held_d[i] = data_byte_i;
      end
    end
  end

  assign job_push_o = accept && (ctl.esc || ctl.tail_valid || emit_cnt != '0);
  assign job_ctl_o  = ctl;
  assign job_cnt_o  = emit_cnt;
  assign job_held_o = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

FILE: rtl/tief_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tief_job_fifo
// Short job queue between the parser front end and the emitting back end.
// ----------------------------------------------------------------------------
module tief_job_fifo #(
  parameter int W     = 10,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         rd_i,
  output logic [W-1:0] rdata_o,
  output logic         valid_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [NW-1:0] num_q, num_d;
  logic          do_wr, do_rd;

  assign full_o  = num_q == NW'(DEPTH);
  assign valid_o = num_q != '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    num_d  = num_q;
    if (do_wr) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      num_d = num_q + NW'(1);
    end else if (do_rd && !do_wr) begin
      num_d = num_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      num_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      num_q  <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/tief_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tief_back
// Walks the head job one beat per cycle, unless the result stage is full and
// not popped: escape, held bytes, tail byte, into a registered result stage.
// ----------------------------------------------------------------------------
module tief_back #(
  parameter int HELD_N = 14,
  parameter int CW     = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  tief_pkg::job_ctl_t     job_ctl_i,
  input  logic [CW-1:0]          job_cnt_i,
  input  logic [HELD_N-1:0][7:0] job_held_i,
  output logic                   job_pop_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic [7:0]             out_byte_o,
  output logic                   run_last_o
);
  import tief_pkg::*;

  localparam int PW = $clog2(HELD_N + 3);

  logic [PW-1:0] pos_q, pos_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q;
  logic          out_last_q;

  logic [PW-1:0] total;
  logic [PW-1:0] k;
  logic          last_beat;
  logic          load;
  logic [7:0]    beat_byte;
  logic [7:0]    held_sel;

  assign total     = PW'(job_ctl_i.esc) + PW'(job_cnt_i) + PW'(job_ctl_i.tail_valid);
  assign last_beat = pos_q == total - PW'(1);
  assign k         = pos_q - PW'(job_ctl_i.esc);
  assign load      = job_valid_i && (!out_valid_q || pop_i);
  assign job_pop_o = load && last_beat;

  always_comb begin
    held_sel = '0;
    for (int i = 0; i < HELD_N; i++) begin
      if (k == PW'(i)) begin
        held_sel = job_held_i[i];
      end
    end
  end

  always_comb begin
    if (job_ctl_i.esc && pos_q == '0) begin
      beat_byte = ESC_BYTE;
    end else if (k < PW'(job_cnt_i)) begin
      beat_byte = held_sel;
    end else begin
      beat_byte = job_ctl_i.tail_byte;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      pos_d       = last_beat ? '0 : pos_q + PW'(1);
    end else if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= beat_byte;
      out_last_q <= last_beat;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign run_last_o = out_last_q;

endmodule

FILE: rtl/terminal_input_escape_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_input_escape_filter_top
// Keyboard byte sanitizer: passes printable and safe control bytes, holds
// escape sequences and emits only well formed CSI and SS3 sequences.
// The first result of a byte passes the job queue, then the result register.
// Throughput: one byte per cycle in and out while the queue has room and the
// receiver pops; a byte with more than one result holds the back end until
// its last result is loaded, and input stalls once the job queue fills.
// Reset: asynchronous, clears parser mode, held count and queues at once.
// ----------------------------------------------------------------------------
module terminal_input_escape_filter_top #(
  parameter int SEQ_DEPTH = 16,
  parameter int JOB_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] data_byte_i,
  input  logic       message_end_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);
  import tief_pkg::*;

  localparam int HELD_N = SEQ_DEPTH - 2;
  localparam int CW     = $clog2(HELD_N + 1);
  localparam int CTL_W  = $bits(job_ctl_t);
  localparam int JW     = CTL_W + CW + 8 * HELD_N;

  logic                   q_full;
  logic                   job_push;
  job_ctl_t               wr_ctl;
  logic [CW-1:0]          wr_cnt;
  logic [HELD_N-1:0][7:0] wr_held;

  logic                   job_valid;
  logic                   job_pop;
  logic [JW-1:0]          rd_data;
  job_ctl_t               rd_ctl;
  logic [CW-1:0]          rd_cnt;
  logic [HELD_N-1:0][7:0] rd_held;

  tief_front #(
    .HELD_N (HELD_N),
    .CW     (CW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .data_byte_i   (data_byte_i),
    .message_end_i (message_end_i),
    .full_o        (full_o),
    .q_full_i      (q_full),
    .job_push_o    (job_push),
    .job_ctl_o     (wr_ctl),
    .job_cnt_o     (wr_cnt),
    .job_held_o    (wr_held)
  );

  tief_job_fifo #(
    .W     (JW),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_push),
    .wdata_i ({wr_ctl, wr_cnt, wr_held}),
    .full_o  (q_full),
    .rd_i    (job_pop),
    .rdata_o (rd_data),
    .valid_o (job_valid)
  );

  assign rd_ctl  = rd_data[JW-1 -: CTL_W];
  assign rd_cnt  = rd_data[8*HELD_N +: CW];
  assign rd_held = rd_data[8*HELD_N-1:0];

  tief_back #(
    .HELD_N (HELD_N),
    .CW     (CW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ctl_i   (rd_ctl),
    .job_cnt_i   (rd_cnt),
    .job_held_i  (rd_held),
    .job_pop_o   (job_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

FILE: verif/tb_terminal_input_escape_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_input_escape_filter_top
// Self-checking bench for the keyboard byte sanitizer. A queue-fed driver
// pushes bytes with message marks, a byte-level predictor of the parser
// builds the expected output beats, and a monitor pops and compares them.
// Runs directed corner bytes and sequences, then random traffic made mostly
// of CSI and SS3 sequences, under several sender and receiver idle mixes and
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_terminal_input_escape_filter_top;
  import tief_pkg::*;

  localparam int SEQ_DEPTH = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SUB = 8'h1a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_CSI = 8'h5b;
  localparam logic [7:0] CH_SS3 = 8'h4f;

  typedef enum logic [1:0] {FM_IDLE, FM_ESC, FM_CSI, FM_SS3} filt_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eom;
  } key_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push_i = 1'b0;
  logic       full_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       message_end_i = 1'b0;
  logic       empty_o;
  logic       pop_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  string csi_params = "0123456789;?:";
  string csi_finals = "ABCDFH~";
  string ss3_finals = "ABCDFHPQRS";

  key_beat_t  pend_q[$];
  out_beat_t  want_q[$];

  filt_mode_e fm_mode = FM_IDLE;
  logic [7:0] fm_held[SEQ_DEPTH];
  int         fm_held_n = 0;
  int         step_beats;

  int n_queued = 0;
  int n_taken = 0;
  int n_beats = 0;
  int n_seq_ok = 0;
  int n_seq_bad = 0;
  int errs = 0;
  int src_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  terminal_input_escape_filter_top #(
    .SEQ_DEPTH(SEQ_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .data_byte_i  (data_byte_i),
    .message_end_i(message_end_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // parser predictor
  function automatic bit in_set(logic [7:0] b, string s);
    for (int k = 0; k < s.len(); k++) begin
      if (s[k] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void emit(logic [7:0] ch);
    out_beat_t w;
    w.ch = ch;
    w.last = 1'b0;
    want_q.push_back(w);
    step_beats++;
  endfunction

  function automatic void flush_held();
    for (int k = 0; k < fm_held_n; k++) emit(fm_held[k]);
    fm_held_n = 0;
    fm_mode = FM_IDLE;
  endfunction

  function automatic void hold_byte(logic [7:0] b);
    if (fm_held_n < SEQ_DEPTH) begin
      fm_held[fm_held_n] = b;
      fm_held_n++;
    end
  endfunction

  function automatic void take_idle(logic [7:0] b);
    if (b == ESC_BYTE) begin
      fm_mode = FM_ESC;
      fm_held_n = 0;
    end else if (b >= CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR ||
                 b == CH_BS || b == CH_DEL || b == CH_ETX || b == CH_EOT ||
                 b == CH_SUB) begin
      emit(b);
    end
  endfunction

  function automatic void abort_seq(logic [7:0] b);
    n_seq_bad++;
    flush_held();
    take_idle(b);
  endfunction

  function automatic void finish_seq(logic [7:0] b);
    n_seq_ok++;
    emit(ESC_BYTE);
    flush_held();
    emit(b);
  endfunction

  function automatic void predict_filter(logic [7:0] b, logic eom);
    step_beats = 0;
    case (fm_mode)
      FM_ESC: begin
        if (b == CH_CSI || b == CH_SS3) begin
          fm_held_n = 0;
          hold_byte(b);
          fm_mode = (b == CH_CSI) ? FM_CSI : FM_SS3;
        end else begin
          abort_seq(b);
        end
      end
      FM_CSI: begin
        if (in_set(b, csi_params)) begin
          if (fm_held_n + 3 <= SEQ_DEPTH) hold_byte(b);
          else abort_seq(b);
        end else if (in_set(b, csi_finals)) begin
          finish_seq(b);
        end else begin
          abort_seq(b);
        end
      end
      FM_SS3: begin
        if (in_set(b, ss3_finals)) finish_seq(b);
        else abort_seq(b);
      end
      default: take_idle(b);
    endcase
    if (eom && fm_mode != FM_IDLE) begin
      n_seq_bad++;
      flush_held();
    end
    if (step_beats > 0) want_q[want_q.size() - 1].last = 1'b1;
  endfunction

  // driver
  always @(posedge clk_i) begin : key_driver
    key_beat_t nxt;
    if (rst_ni) begin
      if (push_i && !full_o) begin
        predict_filter(data_byte_i, message_end_i);
        n_taken++;
      end
      if (!push_i || !full_o) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pend_q.pop_front();
          push_i <= 1'b1;
          data_byte_i <= nxt.ch;
          message_end_i <= nxt.eom;
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_OFF_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin : beat_monitor
    out_beat_t w;
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        n_beats++;
        if (want_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected beat %0d: byte %02h last %0b", n_beats, out_byte_o,
                     run_last_o);
        end else begin
          w = want_q.pop_front();
          if (w.ch !== out_byte_o || w.last !== run_last_o) begin
            errs++;
            if (errs <= 10)
              $display("mismatch at beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                       n_beats, w.ch, w.last, out_byte_o, run_last_o);
          end
        end
      end
      pop_i <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic queue_key(logic [7:0] ch, logic eom);
    key_beat_t k;
    k.ch = ch;
    k.eom = eom;
    pend_q.push_back(k);
    n_queued++;
  endtask

  task automatic queue_random(int n);
    int start;
    int pick;
    int np;
    start = n_queued;
    while (n_queued - start < n) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        repeat ($urandom_range(1, 4))
          queue_key(8'($urandom_range(255)), $urandom_range(9) == 0);
      end else if (pick < 65) begin
        queue_key(ESC_BYTE, $urandom_range(39) == 0);
        queue_key(CH_CSI, $urandom_range(29) == 0);
        np = ($urandom_range(7) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 4);
        repeat (np)
          queue_key(csi_params[$urandom_range(csi_params.len() - 1)],
                    $urandom_range(39) == 0);
        if ($urandom_range(9) == 0)
          queue_key(8'($urandom_range(255)), $urandom_range(4) == 0);
        else queue_key(csi_finals[$urandom_range(csi_finals.len() - 1)],
                       $urandom_range(4) == 0);
      end else if (pick < 85) begin
        queue_key(ESC_BYTE, 1'b0);
        queue_key(CH_SS3, $urandom_range(29) == 0);
        if ($urandom_range(6) == 0)
          queue_key(8'($urandom_range(255)), $urandom_range(4) == 0);
        else queue_key(ss3_finals[$urandom_range(ss3_finals.len() - 1)],
                       $urandom_range(4) == 0);
      end else begin
        queue_key(ESC_BYTE, $urandom_range(3) == 0);
        queue_key(8'($urandom_range(255)), $urandom_range(3) == 0);
      end
    end
  endtask

  task automatic drain_keys();
    while (n_taken != n_queued) @(negedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corner bytes and sequences
    queue_key(8'h00, 1'b0);
    queue_key(8'h1f, 1'b0);
    queue_key(CH_SPACE, 1'b0);
    queue_key(8'hff, 1'b0);
    queue_key(CH_DEL, 1'b0);
    queue_key(CH_TAB, 1'b0);
    queue_key(CH_LF, 1'b0);
    queue_key(CH_CR, 1'b0);
    queue_key(CH_BS, 1'b0);
    queue_key(CH_ETX, 1'b0);
    queue_key(CH_EOT, 1'b0);
    queue_key(CH_SUB, 1'b1);
    queue_key(ESC_BYTE, 1'b0);
    queue_key(CH_CSI, 1'b0);
    queue_key("1", 1'b0);
    queue_key("~", 1'b0);
    queue_key(ESC_BYTE, 1'b0);
    queue_key(CH_SS3, 1'b0);
    queue_key("S", 1'b0);
    queue_key(ESC_BYTE, 1'b0);
    queue_key(ESC_BYTE, 1'b0);
    queue_key(CH_CSI, 1'b0);
    queue_key("Z", 1'b0);
    queue_key(ESC_BYTE, 1'b0);
    queue_key(CH_CSI, 1'b1);
    queue_key(ESC_BYTE, 1'b1);
    // overlong parameter run
    queue_key(ESC_BYTE, 1'b0);
    queue_key(CH_CSI, 1'b0);
    repeat (15) queue_key("9", 1'b0);
    queue_key("A", 1'b0);
    queue_random(48);
    drain_keys();

    // receiver holds off while the sender keeps pushing
    hold_reqs++;
    queue_random(36);
    drain_keys();

    src_idle_pct = 85;
    queue_random(48);
    drain_keys();

    src_idle_pct = 0;
    rcv_stall_pct = 85;
    queue_random(48);
    drain_keys();

    src_idle_pct = 33;
    rcv_stall_pct = 33;
    queue_random(48);
    drain_keys();

    rcv_stall_pct = 0;
    while (want_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run covered %0d input bytes and %0d output beats", n_taken, n_beats);
    $display("escape sequences: %0d passed whole, %0d dropped; %0d mismatches",
             n_seq_ok, n_seq_bad, errs);
    if (errs == 0 && want_q.size() == 0) begin
      $display("terminal_input_escape_filter_top verification clean");
    end else begin
      $display("terminal_input_escape_filter_top verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d of %0d bytes taken, %0d beats pending", n_taken, n_queued,
             want_q.size());
    $display("terminal_input_escape_filter_top verification failed");
    $finish;
  end

endmodule
